// ===== hdl/jgp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jgp_pkg;

  // Geometry defaults
  localparam int SCREEN_WIDTH_DEF = 320;
  localparam int CHAR_WIDTH_DEF   = 8;
  localparam int CHAR_HEIGHT_DEF  = 16;

  localparam logic [7:0] TEXT_COLOR_RESET = 8'd15;

  // Request operation codes
  localparam logic OP_SET_POS = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  // Control bytes
  localparam logic [7:0] BYTE_NUL = 8'd0;
  localparam logic [7:0] BYTE_TAB = 8'd9;
  localparam logic [7:0] BYTE_LF  = 8'd10;

  typedef struct packed {
    logic [7:0] initial_glyph;
    logic       initial_present;
    logic [6:0] medial_glyph;
    logic       medial_present;
    logic [6:0] final_glyph;
    logic       final_present;
  } jamo_t;

  typedef struct packed {
    logic       is_hangul;
    logic [9:0] place_x;
    logic [9:0] place_y;
    logic [7:0] color;
    logic [6:0] english_code;
    jamo_t      jamo;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/jgp_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface jgp_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [9:0] new_x;
  logic [9:0] new_y;
  logic [7:0] code_byte;

  modport source(output valid, output operation, output new_x, output new_y,
                 output code_byte, input ready);
  modport sink(input valid, input operation, input new_x, input new_y,
               input code_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/jgp_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface jgp_out_if;
  logic       valid;
  logic       ready;
  logic       is_hangul;
  logic [9:0] place_x;
  logic [9:0] place_y;
  logic [7:0] color;
  logic [6:0] english_code;
  logic [7:0] initial_glyph;
  logic       initial_present;
  logic [6:0] medial_glyph;
  logic       medial_present;
  logic [6:0] final_glyph;
  logic       final_present;

  modport source(output valid, output is_hangul, output place_x, output place_y,
                 output color, output english_code, output initial_glyph,
                 output initial_present, output medial_glyph, output medial_present,
                 output final_glyph, output final_present, input ready);
  modport sink(input valid, input is_hangul, input place_x, input place_y,
               input color, input english_code, input initial_glyph,
               input initial_present, input medial_glyph, input medial_present,
               input final_glyph, input final_present, output ready);
endinterface

`default_nettype wire

// ===== hdl/jgp_hangul_dec.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Split a Johab pair into jamo and pick font variants.
module jgp_hangul_dec (
  input  wire logic [7:0]     lead_byte,
  input  wire logic [7:0]     trail_byte,
  output jgp_pkg::jamo_t      jamo
);

  function automatic logic [4:0] ini_map(input logic [4:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 5'd2 && c <= 5'd20) r = c - 5'd1;
    return r;
  endfunction

  function automatic logic [4:0] med_map(input logic [4:0] c);
    logic [4:0] r;
    case (c)
      5'd3:  r = 5'd1;   5'd4:  r = 5'd2;   5'd5:  r = 5'd3;
      5'd6:  r = 5'd4;   5'd7:  r = 5'd5;   5'd10: r = 5'd6;
      5'd11: r = 5'd7;   5'd12: r = 5'd8;   5'd13: r = 5'd9;
      5'd14: r = 5'd10;  5'd15: r = 5'd11;  5'd18: r = 5'd12;
      5'd19: r = 5'd13;  5'd20: r = 5'd14;  5'd21: r = 5'd15;
      5'd22: r = 5'd16;  5'd23: r = 5'd17;  5'd26: r = 5'd18;
      5'd27: r = 5'd19;  5'd28: r = 5'd20;  5'd29: r = 5'd21;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] fin_map(input logic [4:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 5'd2 && c <= 5'd17) r = c - 5'd1;
    else if (c >= 5'd19 && c <= 5'd29) r = c - 5'd2;
    return r;
  endfunction

  // Final variant by medial index.
  function automatic logic [1:0] fin_var(input logic [4:0] m);
    logic [1:0] r;
    case (m)
      5'd2, 5'd4, 5'd6, 5'd8, 5'd11, 5'd16:                 r = 2'd2;
      5'd5, 5'd7, 5'd12, 5'd15, 5'd17, 5'd20, 5'd21:        r = 2'd1;
      5'd9, 5'd13, 5'd14, 5'd18, 5'd19:                     r = 2'd3;
      default:                                              r = 2'd0;
    endcase
    return r;
  endfunction

  // Medial variant by initial index and whether a final is present.
  function automatic logic [1:0] med_var(input logic has_fin, input logic [4:0] i);
    logic [1:0] r;
    if (i == 5'd0) r = 2'd0;
    else if (i == 5'd1 || i == 5'd16) r = has_fin ? 2'd2 : 2'd0;
    else r = has_fin ? 2'd3 : 2'd1;
    return r;
  endfunction

  // Initial variant by medial index and whether a final is present.
  function automatic logic [2:0] ini_var(input logic has_fin, input logic [4:0] m);
    logic [2:0] r;
    if (!has_fin) begin
      case (m)
        5'd9, 5'd13, 5'd19:                    r = 3'd1;
        5'd14, 5'd18:                          r = 3'd2;
        5'd10, 5'd11, 5'd12, 5'd20:            r = 3'd3;
        5'd15, 5'd16, 5'd17:                   r = 3'd4;
        default:                               r = 3'd0;
      endcase
    end else begin
      case (m)
        5'd0:                                  r = 3'd0;
        5'd9, 5'd13, 5'd14, 5'd18, 5'd19:      r = 3'd6;
        5'd10, 5'd11, 5'd12, 5'd15, 5'd16, 5'd17, 5'd20: r = 3'd7;
        default:                               r = 3'd5;
      endcase
    end
    return r;
  endfunction

  logic [4:0] fi, mi, la;
  logic       has_fin;
  logic [2:0] vi;
  logic [1:0] vm, vf;

  always_comb begin
    fi      = ini_map(lead_byte[6:2]);
    mi      = med_map({lead_byte[1:0], trail_byte[7:5]});
    la      = fin_map(trail_byte[4:0]);
    has_fin = (la != 5'd0);
    vf      = fin_var(mi);
    vm      = med_var(has_fin, fi);
    vi      = ini_var(has_fin, mi);

    jamo.initial_present = (fi != 5'd0);
    jamo.medial_present  = (mi != 5'd0);
    jamo.final_present   = has_fin;
    jamo.initial_glyph   = jamo.initial_present ?
                           ({5'd0, vi} * 8'd20 + {3'd0, fi}) : 8'd0;
    jamo.medial_glyph    = jamo.medial_present ?
                           ({5'd0, vm} * 7'd22 + {2'd0, mi}) : 7'd0;
    jamo.final_glyph     = has_fin ?
                           ({5'd0, vf} * 7'd28 + {2'd0, la}) : 7'd0;
  end

endmodule

`default_nettype wire

// ===== hdl/jgp_out_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Output register with a skid entry behind it.
module jgp_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire jgp_pkg::result_t  push_data,
  output logic                   push_ready,
  output logic                   out_valid,
  output jgp_pkg::result_t       out_data,
  input  wire logic              out_ready
);

  logic             main_valid;
  jgp_pkg::result_t main_data;
  logic             skid_valid;
  jgp_pkg::result_t skid_data;
  logic             pop;

  assign pop        = main_valid && out_ready;
  assign push_ready = !skid_valid;
  assign out_valid  = main_valid;
  assign out_data   = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
        main_data  <= push_data;
      end
    end else if (!main_valid) begin
      main_valid <= push;
      main_data  <= push_data;
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/johab_text_glyph_placer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Johab text glyph placer.
// text_in carries requests: operation 0 loads the cursor from new_x/new_y,
// operation 1 hands over one text byte in code_byte. glyph_out carries one
// placement per character: position, color, an English code or
// three Hangul jamo font indices with present flags.
// A byte above 127 is held as a lead byte and produces its glyph with the
// next text byte. Tab, newline, zero bytes, lead bytes and cursor loads
// update state only and produce nothing.
// Throughput: one request per cycle while text_in.ready is high. The cursor update and
// the glyph decode are finished in the cycle of acceptance, so the next request sees the
// new cursor at once. Unless glyph_out stalls, a result is valid the cycle after its request.
// Writes to text_color (cfg_we/cfg_data) take effect on the next request.
// When glyph_out stalls, the output register holds and one more result
// lands in a skid entry; text_in.ready drops only while that entry is full.
// Reset (rst, synchronous) clears the cursor, the pending lead byte and
// both output entries, and loads text_color with 15.
module johab_text_glyph_placer #(
  parameter int SCREEN_WIDTH = jgp_pkg::SCREEN_WIDTH_DEF,
  parameter int CHAR_WIDTH   = jgp_pkg::CHAR_WIDTH_DEF,
  parameter int CHAR_HEIGHT  = jgp_pkg::CHAR_HEIGHT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_data,
  jgp_in_if.sink           text_in,
  jgp_out_if.source        glyph_out
);

  localparam logic [10:0] CurMax      = 11'd1023;
  localparam logic [10:0] EngLimit    = 11'(SCREEN_WIDTH - CHAR_WIDTH);
  localparam logic [10:0] HanLimit    = 11'(SCREEN_WIDTH - 2 * CHAR_WIDTH);
  localparam logic [10:0] EngStep     = 11'(CHAR_WIDTH);
  localparam logic [10:0] HanStep     = 11'(2 * CHAR_WIDTH);
  localparam logic [10:0] RowStep     = 11'(CHAR_HEIGHT);
  // Column number by reciprocal multiply; exact for any 10-bit cursor.
  localparam int          RecipShift  = 20;
  localparam logic [18:0] TabRecip    = 19'((2 ** RecipShift + CHAR_WIDTH - 1) / CHAR_WIDTH);

  function automatic logic [9:0] sat_add(input logic [9:0] a, input logic [10:0] b);
    logic [10:0] s;
    s = {1'b0, a} + b;
    return (s > CurMax) ? CurMax[9:0] : s[9:0];
  endfunction

  // State
  logic [7:0] text_color;
  logic [9:0] cursor_x, cursor_x_next;
  logic [9:0] cursor_y, cursor_y_next;
  logic       lead_pending, lead_pending_next;
  logic [7:0] lead_byte, lead_byte_next;

  logic             accept;
  logic             push;
  logic             push_ready;
  jgp_pkg::result_t res;
  jgp_pkg::jamo_t   jamo;
  jgp_pkg::result_t out_data;
  logic             out_valid;

  logic [28:0] col_prod;
  logic [2:0]  col_low;
  logic [10:0] tab_adv;
  logic        wrap;
  logic [9:0]  px, py;

  jgp_hangul_dec u_dec (
    .lead_byte  (lead_byte),
    .trail_byte (text_in.code_byte),
    .jamo       (jamo)
  );

  assign accept        = text_in.valid && push_ready;
  assign text_in.ready = push_ready;

  always_comb begin
    col_prod = 29'(cursor_x) * 29'(TabRecip);
    col_low  = col_prod[RecipShift +: 3];
    tab_adv  = 11'((4'd8 - {1'b0, col_low}) * CHAR_WIDTH);

    // Wrap check against the limit for the glyph kind this byte would place.
    wrap = lead_pending ? ({1'b0, cursor_x} > HanLimit) : ({1'b0, cursor_x} > EngLimit);
    px   = wrap ? 10'd0 : cursor_x;
    py   = wrap ? sat_add(cursor_y, RowStep) : cursor_y;

    cursor_x_next     = cursor_x;
    cursor_y_next     = cursor_y;
    lead_pending_next = lead_pending;
    lead_byte_next    = lead_byte;
    push              = 1'b0;

    res              = '0;
    res.place_x      = px;
    res.place_y      = py;
    res.color        = text_color;

    if (text_in.operation == jgp_pkg::OP_SET_POS) begin
      cursor_x_next     = text_in.new_x;
      cursor_y_next     = text_in.new_y;
      lead_pending_next = 1'b0;
    end else if (lead_pending) begin
      // Any byte completes the pair.
      lead_pending_next = 1'b0;
      push              = 1'b1;
      res.is_hangul     = 1'b1;
      res.jamo          = jamo;
      cursor_x_next     = sat_add(px, HanStep);
      cursor_y_next     = py;
    end else if (text_in.code_byte == jgp_pkg::BYTE_NUL) begin
      // Drop.
    end else if (text_in.code_byte == jgp_pkg::BYTE_TAB) begin
      cursor_x_next = sat_add(cursor_x, tab_adv);
    end else if (text_in.code_byte == jgp_pkg::BYTE_LF) begin
      cursor_x_next = 10'd0;
      cursor_y_next = sat_add(cursor_y, RowStep);
    end else if (text_in.code_byte[7]) begin
      lead_byte_next    = text_in.code_byte;
      lead_pending_next = 1'b1;
    end else begin
      push             = 1'b1;
      res.english_code = text_in.code_byte[6:0];
      cursor_x_next    = sat_add(px, EngStep);
      cursor_y_next    = py;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color   <= jgp_pkg::TEXT_COLOR_RESET;
      cursor_x     <= 10'd0;
      cursor_y     <= 10'd0;
      lead_pending <= 1'b0;
      lead_byte    <= 8'd0;
    end else begin
      if (cfg_we) begin
        text_color <= cfg_data;
      end
      if (accept) begin
        cursor_x     <= cursor_x_next;
        cursor_y     <= cursor_y_next;
        lead_pending <= lead_pending_next;
        lead_byte    <= lead_byte_next;
      end
    end
  end

  jgp_out_buf u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (accept && push),
    .push_data  (res),
    .push_ready (push_ready),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_ready  (glyph_out.ready)
  );

  assign glyph_out.valid           = out_valid;
  assign glyph_out.is_hangul       = out_data.is_hangul;
  assign glyph_out.place_x         = out_data.place_x;
  assign glyph_out.place_y         = out_data.place_y;
  assign glyph_out.color           = out_data.color;
  assign glyph_out.english_code    = out_data.english_code;
  assign glyph_out.initial_glyph   = out_data.jamo.initial_glyph;
  assign glyph_out.initial_present = out_data.jamo.initial_present;
  assign glyph_out.medial_glyph    = out_data.jamo.medial_glyph;
  assign glyph_out.medial_present  = out_data.jamo.medial_present;
  assign glyph_out.final_glyph     = out_data.jamo.final_glyph;
  assign glyph_out.final_present   = out_data.jamo.final_present;

endmodule

`default_nettype wire

// ===== hdl/jgp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jgp_checker #(
  parameter int SCREEN_WIDTH = jgp_pkg::SCREEN_WIDTH_DEF,
  parameter int CHAR_WIDTH   = jgp_pkg::CHAR_WIDTH_DEF
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       is_hangul,
  input wire logic [9:0] place_x,
  input wire logic [6:0] english_code,
  input wire logic [7:0] initial_glyph,
  input wire logic       initial_present,
  input wire logic [6:0] medial_glyph,
  input wire logic       medial_present,
  input wire logic [6:0] final_glyph,
  input wire logic       final_present
);

  localparam logic [10:0] EngLimit = 11'(SCREEN_WIDTH - CHAR_WIDTH);
  localparam logic [10:0] HanLimit = 11'(SCREEN_WIDTH - 2 * CHAR_WIDTH);

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

  // A stalled result keeps its position.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(place_x))
    else $error("stalled result changed");

  // English results carry a nonzero code and no jamo.
  a_english: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_hangul |-> english_code != 7'd0 && !initial_present
      && !medial_present && !final_present && initial_glyph == 8'd0
      && medial_glyph == 7'd0 && final_glyph == 7'd0)
    else $error("malformed English result");

  // Hangul results carry no English code and zero absent jamo.
  a_hangul: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_hangul |-> english_code == 7'd0
      && (initial_present || initial_glyph == 8'd0)
      && (medial_present || medial_glyph == 7'd0)
      && (final_present || final_glyph == 7'd0))
    else $error("malformed Hangul result");

  // Wrap keeps every glyph inside the screen.
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, place_x} <= (is_hangul ? HanLimit : EngLimit))
      || place_x == 10'd0)
    else $error("glyph placed past the right edge");

endmodule

bind johab_text_glyph_placer jgp_checker #(
  .SCREEN_WIDTH (SCREEN_WIDTH),
  .CHAR_WIDTH   (CHAR_WIDTH)
) u_jgp_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (glyph_out.valid),
  .out_ready       (glyph_out.ready),
  .is_hangul       (glyph_out.is_hangul),
  .place_x         (glyph_out.place_x),
  .english_code    (glyph_out.english_code),
  .initial_glyph   (glyph_out.initial_glyph),
  .initial_present (glyph_out.initial_present),
  .medial_glyph    (glyph_out.medial_glyph),
  .medial_present  (glyph_out.medial_present),
  .final_glyph     (glyph_out.final_glyph),
  .final_present   (glyph_out.final_present)
);

`default_nettype wire
